FILE: hw/rtl/dtp_pkg.sv
// Shared constants and types for the DHCP option TLV parser.
package dtp_pkg;

    localparam logic [7:0] TAG_PAD    = 8'd0;
    localparam logic [7:0] TAG_MASK   = 8'd1;
    localparam logic [7:0] TAG_ROUTER = 8'd3;
    localparam logic [7:0] TAG_LEASE  = 8'd51;
    localparam logic [7:0] TAG_TYPE   = 8'd53;
    localparam logic [7:0] TAG_SERVER = 8'd54;
    localparam logic [7:0] TAG_END    = 8'd255;

    // Number of value bytes kept per option.
    localparam logic [2:0] VALUE_KEEP = 3'd4;

    typedef struct packed {
        logic [7:0]  message_type;
        logic [31:0] server_id;
        logic [31:0] netmask;
        logic [31:0] router_address;
        logic [31:0] lease_seconds;
        logic        malformed;
        logic        end_seen;
    } result_t;

endpackage

FILE: hw/rtl/dhcp_option_tlv_parser.sv
// Top level of the DHCP option TLV parser: byte input, per-message result output.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one byte of a DHCP options area
//   per request, option_byte plus last_byte, which marks the final byte of
//   the message. Pad bytes are skipped, the end option stops parsing, and
//   message type, server id, subnet mask, router and lease time are taken
//   from their options once each option has fully arrived.
//   Output channel (out_valid/out_ready) carries one result request per
//   message, produced by the request with last_byte set.
//   Throughput: one byte per cycle while no final byte waits on a full
//   result slot. Each byte is parsed while it sits in the input register;
//   the result of its final byte is then registered in the output register.
//   The stored addresses and lease time persist across messages; message
//   type, malformed and end flags restart with every message.
//   Reset clears all parse state, stored values and the valid flags of both registers.
//   Stall: while a result waits unaccepted, non-final bytes keep flowing;
//   the next final byte holds in the input register until the slot frees.
module dhcp_option_tlv_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  option_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  message_type,
    output logic [31:0] server_id,
    output logic [31:0] netmask,
    output logic [31:0] router_address,
    output logic [31:0] lease_seconds,
    output logic        malformed,
    output logic        end_seen
);

    logic             held_valid;
    logic [7:0]       held_byte;
    logic             held_last;
    logic             out_free;
    logic             step;
    dtp_pkg::result_t step_res;
    dtp_pkg::result_t out_res;

    // Advance the parser unless a final byte would overwrite a waiting result.
    assign step = held_valid && (!held_last || out_free);

    dtp_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .option_byte (option_byte),
        .last_byte   (last_byte),
        .take        (step),
        .held_valid  (held_valid),
        .held_byte   (held_byte),
        .held_last   (held_last)
    );

    dtp_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cur_byte (held_byte),
        .cur_last (held_last),
        .result   (step_res)
    );

    dtp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && held_last),
        .load_res  (step_res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held_res  (out_res)
    );

    assign message_type   = out_res.message_type;
    assign server_id      = out_res.server_id;
    assign netmask        = out_res.netmask;
    assign router_address = out_res.router_address;
    assign lease_seconds  = out_res.lease_seconds;
    assign malformed      = out_res.malformed;
    assign end_seen       = out_res.end_seen;

`ifndef NO_ASSERTIONS
    // A held byte that is not parsed must still be held next cycle.
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !step |=> held_valid)
        else $error("held byte dropped without being parsed");

    // A parsed final byte always produces a result.
    a_result_made: assert property (@(posedge clk) disable iff (!rst_n)
        step && held_last |=> out_valid)
        else $error("final byte parsed without a result");

    // Never overwrite a result the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(step && held_last))
        else $error("waiting result overwritten");
`endif

endmodule

FILE: hw/rtl/dtp_in_stage.sv
// Input register stage: holds one option byte request until the parser takes it.
module dtp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] option_byte,
    input  logic       last_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_last
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Accept a new request when empty or when the held one leaves this cycle.
    assign in_ready = !vld_reg || take;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= option_byte;
            last_reg <= last_byte;
        end
    end

    assign held_valid = vld_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

FILE: hw/rtl/dtp_parse.sv
// Option parser: TLV state machine, value assembly and stored option values.
module dtp_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      cur_byte,
    input  logic            cur_last,
    output dtp_pkg::result_t result
);

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  tag_reg,     tag_next;
    logic [7:0]  left_reg,    left_next;
    logic [2:0]  vidx_reg,    vidx_next;
    logic [31:0] pend_reg,    pend_next;
    logic [7:0]  type_reg,    type_next;
    logic [31:0] server_reg,  server_next;
    logic [31:0] mask_reg,    mask_next;
    logic [31:0] router_reg,  router_next;
    logic [31:0] lease_reg,   lease_next;
    logic        mal_reg,     mal_next;
    logic        end_reg,     end_next;
    logic        commit;

    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        vidx_next   = vidx_reg;
        pend_next   = pend_reg;
        type_next   = type_reg;
        server_next = server_reg;
        mask_next   = mask_reg;
        router_next = router_reg;
        lease_next  = lease_reg;
        mal_next    = mal_reg;
        end_next    = end_reg;
        commit      = 1'b0;

        unique case (phase_reg)
            PH_TAG:
            begin
                if (cur_byte == dtp_pkg::TAG_END)
                begin
                    end_next   = 1'b1;
                    phase_next = PH_DONE;
                end
                else if (cur_byte != dtp_pkg::TAG_PAD)
                begin
                    tag_next   = cur_byte;
                    phase_next = PH_LEN;
                    if (cur_last)
                    begin
                        mal_next = 1'b1;
                    end
                end
            end
            PH_LEN:
            begin
                left_next = cur_byte;
                vidx_next = 3'd0;
                pend_next = 32'd0;
                if (cur_byte == 8'd0)
                begin
                    commit     = 1'b1;
                    phase_next = PH_TAG;
                end
                else
                begin
                    phase_next = PH_VAL;
                    if (cur_last)
                    begin
                        mal_next = 1'b1;
                    end
                end
            end
            PH_VAL:
            begin
                // Keep only the first four value bytes, big-endian.
                if (vidx_reg < dtp_pkg::VALUE_KEEP)
                begin
                    pend_next = {pend_reg[23:0], cur_byte};
                    vidx_next = vidx_reg + 3'd1;
                end
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0)
                begin
                    commit     = 1'b1;
                    phase_next = PH_TAG;
                end
                else if (cur_last)
                begin
                    mal_next = 1'b1;
                end
            end
            PH_DONE:
            begin
                // Ignore everything after the end option.
            end
            default:
            begin
                phase_next = PH_TAG;
            end
        endcase

        if (commit)
        begin
            if (tag_reg == dtp_pkg::TAG_TYPE)
            begin
                // The first value byte sits vidx-1 bytes above the bottom.
                case (vidx_next)
                    3'd1:    type_next = pend_next[7:0];
                    3'd2:    type_next = pend_next[15:8];
                    3'd3:    type_next = pend_next[23:16];
                    3'd4:    type_next = pend_next[31:24];
                    default: type_next = type_reg;
                endcase
            end
            else if (vidx_next >= dtp_pkg::VALUE_KEEP)
            begin
                unique case (tag_reg)
                    dtp_pkg::TAG_SERVER: server_next = pend_next;
                    dtp_pkg::TAG_MASK:   mask_next   = pend_next;
                    dtp_pkg::TAG_ROUTER: router_next = pend_next;
                    dtp_pkg::TAG_LEASE:  lease_next  = pend_next;
                    default:             server_next = server_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            tag_reg    <= 8'd0;
            left_reg   <= 8'd0;
            vidx_reg   <= 3'd0;
            pend_reg   <= 32'd0;
            type_reg   <= 8'd0;
            server_reg <= 32'd0;
            mask_reg   <= 32'd0;
            router_reg <= 32'd0;
            lease_reg  <= 32'd0;
            mal_reg    <= 1'b0;
            end_reg    <= 1'b0;
        end
        else if (step)
        begin
            server_reg <= server_next;
            mask_reg   <= mask_next;
            router_reg <= router_next;
            lease_reg  <= lease_next;
            if (cur_last)
            begin
                // Clear per-message state once the result goes out.
                phase_reg <= PH_TAG;
                tag_reg   <= 8'd0;
                left_reg  <= 8'd0;
                vidx_reg  <= 3'd0;
                pend_reg  <= 32'd0;
                type_reg  <= 8'd0;
                mal_reg   <= 1'b0;
                end_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                tag_reg   <= tag_next;
                left_reg  <= left_next;
                vidx_reg  <= vidx_next;
                pend_reg  <= pend_next;
                type_reg  <= type_next;
                mal_reg   <= mal_next;
                end_reg   <= end_next;
            end
        end
    end

    assign result.message_type   = type_next;
    assign result.server_id      = server_next;
    assign result.netmask        = mask_next;
    assign result.router_address = router_next;
    assign result.lease_seconds  = lease_next;
    assign result.malformed      = mal_next;
    assign result.end_seen       = end_next;

endmodule

FILE: hw/rtl/dtp_out_stage.sv
// Result register: holds one message result until the receiver takes it.
module dtp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dtp_pkg::result_t load_res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output dtp_pkg::result_t held_res
);

    logic             vld_reg;
    logic             vld_next;
    dtp_pkg::result_t res_reg;

    // Slot is free when empty or when the held result is taken this cycle.
    assign free = !vld_reg || out_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (out_ready)
        begin
            vld_next = 1'b0;
        end
        if (load)
        begin
            vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = vld_reg;
    assign held_res  = res_reg;

endmodule

FILE: tb/dhcp_option_tlv_parser_tb.sv
// Self-checking testbench for dhcp_option_tlv_parser: byte stimulus, predicted results, checks.
module dhcp_option_tlv_parser_tb;

    // Cycles with no request moving on either channel before the run is abandoned.
    localparam int IDLE_LIMIT = 2000;
    // Cycles to keep watching after the last expected result has come.
    localparam int DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        EXPECT_TAG = 2'd0,
        EXPECT_LEN = 2'd1,
        IN_VALUE   = 2'd2,
        AFTER_END  = 2'd3
    } parse_phase_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_LONG_STALL
    } ready_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  option_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  message_type;
    logic [31:0] server_id;
    logic [31:0] netmask;
    logic [31:0] router_address;
    logic [31:0] lease_seconds;
    logic        malformed;
    logic        end_seen;

    dhcp_option_tlv_parser DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .option_byte    (option_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .message_type   (message_type),
        .server_id      (server_id),
        .netmask        (netmask),
        .router_address (router_address),
        .lease_seconds  (lease_seconds),
        .malformed      (malformed),
        .end_seen       (end_seen)
    );

    // Parser image: per-message state plus the stores that survive across messages.
    parse_phase_t p_phase;
    logic [7:0]   p_tag;
    logic [7:0]   p_left;
    logic [2:0]   p_index;
    logic [31:0]  p_pending;
    logic [7:0]   p_type;
    logic [31:0]  p_server;
    logic [31:0]  p_mask;
    logic [31:0]  p_router;
    logic [31:0]  p_lease;
    logic         p_malformed;
    logic         p_end;

    // Results the parser owes us, oldest first.
    dtp_pkg::result_t expected_results[$];

    // Bytes of the message being built, sent in order.
    logic [7:0] msg_bytes[$];

    int               errors;
    int               bytes_sent;
    int               messages_checked;
    int               malformed_seen;
    int               end_option_seen;
    int               idle_cycles;
    int               burst_left;
    bit               gaps_enabled;
    ready_mode_t      ready_mode;
    int               stall_left;
    dtp_pkg::result_t oldest;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------

    task automatic clear_message_state();
        p_phase     = EXPECT_TAG;
        p_tag       = 8'd0;
        p_left      = 8'd0;
        p_index     = 3'd0;
        p_pending   = 32'd0;
        p_type      = 8'd0;
        p_malformed = 1'b0;
        p_end       = 1'b0;
    endtask

    task automatic reset_parser_image();
        clear_message_state();
        p_server = 32'd0;
        p_mask   = 32'd0;
        p_router = 32'd0;
        p_lease  = 32'd0;
    endtask

    // Commit a finished option. The type takes the first value byte; the
    // 32-bit stores need at least four bytes, first byte most significant.
    task automatic commit_finished_option();
        if (p_tag == dtp_pkg::TAG_TYPE)
        begin
            if (p_index >= 3'd1 && p_index <= dtp_pkg::VALUE_KEEP)
                p_type = 8'(p_pending >> (8 * (p_index - 3'd1)));
        end
        else if (p_index >= dtp_pkg::VALUE_KEEP)
        begin
            if (p_tag == dtp_pkg::TAG_SERVER)
                p_server = p_pending;
            else if (p_tag == dtp_pkg::TAG_MASK)
                p_mask = p_pending;
            else if (p_tag == dtp_pkg::TAG_ROUTER)
                p_router = p_pending;
            else if (p_tag == dtp_pkg::TAG_LEASE)
                p_lease = p_pending;
        end
    endtask

    // Advance the parser image by one accepted byte; queue a result on the final byte.
    task automatic predict_options_byte(input logic [7:0] b, input logic fin);
        dtp_pkg::result_t r;
        case (p_phase)
            EXPECT_TAG:
            begin
                if (b == dtp_pkg::TAG_END)
                begin
                    p_end   = 1'b1;
                    p_phase = AFTER_END;
                end
                else if (b != dtp_pkg::TAG_PAD)
                begin
                    p_tag   = b;
                    p_phase = EXPECT_LEN;
                    if (fin)
                        p_malformed = 1'b1;
                end
            end
            EXPECT_LEN:
            begin
                p_left    = b;
                p_index   = 3'd0;
                p_pending = 32'd0;
                if (b == 8'd0)
                begin
                    commit_finished_option();
                    p_phase = EXPECT_TAG;
                end
                else
                begin
                    p_phase = IN_VALUE;
                    if (fin)
                        p_malformed = 1'b1;
                end
            end
            IN_VALUE:
            begin
                if (p_index < dtp_pkg::VALUE_KEEP)
                begin
                    p_pending = {p_pending[23:0], b};
                    p_index   = p_index + 3'd1;
                end
                p_left = p_left - 8'd1;
                if (p_left == 8'd0)
                begin
                    commit_finished_option();
                    p_phase = EXPECT_TAG;
                end
                else if (fin)
                begin
                    p_malformed = 1'b1;
                end
            end
            default:
            begin
                // Bytes after the end option are ignored.
            end
        endcase

        if (fin)
        begin
            r.message_type   = p_type;
            r.server_id      = p_server;
            r.netmask        = p_mask;
            r.router_address = p_router;
            r.lease_seconds  = p_lease;
            r.malformed      = p_malformed;
            r.end_seen       = p_end;
            expected_results.push_back(r);
            clear_message_state();
        end
    endtask

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Send one byte as one request; hold it until accepted, then predict.
    // Called at a rising edge. Gaps between bursts drop valid for a while.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (gaps_enabled && burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid    <= 1'b1;
        option_byte <= b;
        last_byte   <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        predict_options_byte(b, fin);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Send the built message with the final flag on its last byte.
    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Message builders
    // ---------------------------------------------------------------

    task automatic add_bytes(input int n);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Append one complete option with random content.
    task automatic add_random_option();
        int         kind;
        int         sel;
        int         len;
        int         min_len;
        logic [7:0] tag;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       tag = dtp_pkg::TAG_PAD;
            1:       tag = dtp_pkg::TAG_TYPE;
            2:       tag = dtp_pkg::TAG_SERVER;
            3:       tag = dtp_pkg::TAG_MASK;
            4, 5:    tag = dtp_pkg::TAG_ROUTER;
            6:       tag = dtp_pkg::TAG_LEASE;
            default: tag = 8'($urandom_range(1, 254));
        endcase
        msg_bytes.push_back(tag);
        if (tag == dtp_pkg::TAG_PAD)
            return;
        min_len = (tag == dtp_pkg::TAG_TYPE) ? 1 : 4;
        sel = $urandom_range(0, 39);
        if (sel < 24)
            len = min_len;
        else if (sel < 31)
            len = $urandom_range(0, min_len);
        else if (sel < 39)
            len = $urandom_range(min_len, 10);
        else
            len = $urandom_range(200, 255);
        msg_bytes.push_back(8'(len));
        add_bytes(len);
    endtask

    // A well-formed message: options, maybe an end option and trailing junk.
    task automatic build_well_formed();
        int nopts;
        nopts = $urandom_range(0, 5);
        repeat (nopts) add_random_option();
        if ($urandom_range(0, 2) == 0)
        begin
            msg_bytes.push_back(dtp_pkg::TAG_END);
            add_bytes($urandom_range(0, 3));
        end
        if (msg_bytes.size() == 0)
            msg_bytes.push_back($urandom_range(0, 1) ? dtp_pkg::TAG_END : dtp_pkg::TAG_PAD);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Hand-picked messages: field extremes and a final byte in each parse phase.
    task automatic test_directed();
        // Type and an all-ones server id, end option, a pad byte after the end.
        msg_bytes = '{dtp_pkg::TAG_TYPE, 8'd1, 8'd5, dtp_pkg::TAG_SERVER, 8'd4,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, dtp_pkg::TAG_END, dtp_pkg::TAG_PAD};
        send_message();
        // Server id too short to commit; type with length 0 on the final byte.
        msg_bytes = '{dtp_pkg::TAG_SERVER, 8'd3, 8'h01, 8'h02, 8'h03,
                      dtp_pkg::TAG_TYPE, 8'd0};
        send_message();
        // Unknown option skipped, then a tag lands on the final byte.
        msg_bytes = '{8'd200, 8'd1, 8'h09, dtp_pkg::TAG_MASK};
        send_message();
        // Nonzero length on the final byte.
        msg_bytes = '{dtp_pkg::TAG_ROUTER, 8'd4};
        send_message();
        // Value cut short by the final byte.
        msg_bytes = '{dtp_pkg::TAG_LEASE, 8'd4, 8'h07};
        send_message();
        wait_for_results();
    endtask

    // Well-formed messages so every store gets written and rewritten.
    task automatic test_well_formed(input int nbytes);
        int stop_at;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at)
        begin
            build_well_formed();
            send_message();
        end
    endtask

    // Well-formed messages chopped at a random byte.
    task automatic test_truncated(input int nbytes);
        int stop_at;
        int keep;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at)
        begin
            build_well_formed();
            if (msg_bytes.size() > 1)
            begin
                keep = $urandom_range(1, msg_bytes.size() - 1);
                msg_bytes = msg_bytes[0:keep - 1];
            end
            send_message();
        end
    endtask

    // Short messages of noise, biased toward the pad, end, type and server tags.
    task automatic test_noise(input int nbytes);
        int stop_at;
        int n;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at)
        begin
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                case ($urandom_range(0, 7))
                    0:       msg_bytes.push_back(dtp_pkg::TAG_PAD);
                    1:       msg_bytes.push_back(dtp_pkg::TAG_END);
                    2:       msg_bytes.push_back(dtp_pkg::TAG_TYPE);
                    3:       msg_bytes.push_back(dtp_pkg::TAG_SERVER);
                    default: msg_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            send_message();
        end
    endtask

    // Send a few messages, drain completely, then resume.
    task automatic test_pause_drain();
        repeat (3)
        begin
            build_well_formed();
            send_message();
        end
        wait_for_results();
        repeat (2)
        begin
            build_well_formed();
            send_message();
        end
    endtask

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------

    // Receiver stall pattern, picked per test.
    always @(posedge clk)
    begin
        case (ready_mode)
            READY_ALWAYS:
                out_ready <= 1'b1;
            READY_RANDOM:
                out_ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 11) == 0)
                        stall_left = $urandom_range(4, 30);
                end
            end
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, want, got);
            errors++;
        end
    endtask

    // Compare each accepted result with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: type %h malformed %b end %b",
                         $realtime, message_type, malformed, end_seen);
                errors++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                check_field("message_type", 32'(oldest.message_type), 32'(message_type));
                check_field("server_id", oldest.server_id, server_id);
                check_field("netmask", oldest.netmask, netmask);
                check_field("router_address", oldest.router_address, router_address);
                check_field("lease_seconds", oldest.lease_seconds, lease_seconds);
                check_field("malformed", 32'(oldest.malformed), 32'(malformed));
                check_field("end_seen", 32'(oldest.end_seen), 32'(end_seen));
                messages_checked++;
                if (oldest.malformed)
                    malformed_seen++;
                if (oldest.end_seen)
                    end_option_seen++;
            end
        end
    end

    // Abandon the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAIL dhcp_option_tlv_parser");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        option_byte  = 8'd0;
        last_byte    = 1'b0;
        errors       = 0;
        bytes_sent   = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        stall_left   = 0;
        gaps_enabled = 1'b0;
        ready_mode   = READY_ALWAYS;
        messages_checked = 0;
        malformed_seen   = 0;
        end_option_seen  = 0;
        reset_parser_image();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners at full rate on both sides.
        test_directed();

        // Bursty sender, randomly stalling receiver.
        gaps_enabled = 1'b1;
        ready_mode   = READY_RANDOM;
        test_well_formed(300);

        // Long receiver stalls back up final bytes behind a waiting result.
        ready_mode = READY_LONG_STALL;
        test_truncated(150);

        // Hold off the sender until the pipeline is empty, then resume sending.
        test_pause_drain();

        // Back-to-back traffic with no idling on either side.
        gaps_enabled = 1'b0;
        ready_mode   = READY_ALWAYS;
        test_noise(100);

        // Mixed tail with gaps and random stalls again.
        gaps_enabled = 1'b1;
        ready_mode   = READY_RANDOM;
        test_well_formed(120);
        test_noise(40);

        // Drain and watch a little longer for stray results.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $realtime, expected_results.size());
            errors++;
        end

        $display("Run covered %0d option bytes and %0d messages (%0d malformed, %0d ended).",
                 bytes_sent, messages_checked, malformed_seen, end_option_seen);
        $display("Mismatches found: %0d", errors);
        if (errors == 0)
            $display("PASS dhcp_option_tlv_parser");
        else
            $display("FAIL dhcp_option_tlv_parser");
        $finish;
    end

endmodule
